// ----- src/rfla_pkg.sv -----
package rfla_pkg;

	localparam int MAX_RANGES  = 16;
	localparam int VALUE_BITS  = 32;
	localparam int FIELD_BITS  = 32;
	localparam int STATUS_BITS = 3;
	localparam int IDX_W       = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W       = $clog2(MAX_RANGES + 1);

	typedef logic [VALUE_BITS-1:0]  val_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam val_t VAL_ONES = {VALUE_BITS{1'b1}};

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_INVALID = 3'd1;
	localparam status_t ST_OVERLAP = 3'd2;
	localparam status_t ST_FULL    = 3'd3;
	localparam status_t ST_EMPTY   = 3'd4;

	typedef struct packed {
		logic    ld;
		logic    idx_inc;
		logic    wr_start;
		logic    start_inc;
		logic    wr_end;
		logic    drop;
		logic    merge;
		logic    open;
		logic    res_ld;
		logic    res_ones;
		status_t res_status;
	} rfla_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic at_end;
		logic full;
		logic invalid;
		logic overlap;
		logic prepend;
		logic append;
		logic stop;
		logic has_next;
		logic merge_hit;
		logic single;
	} rfla_stat_t;

endpackage

// ----- src/rfla_req_if.sv -----
interface rfla_req_if;
	import rfla_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [FIELD_BITS-1:0] range_low;
	logic [FIELD_BITS-1:0] range_high;

	modport source (output valid, action, range_low, range_high, input ready);
	modport sink (input valid, action, range_low, range_high, output ready);
endinterface

// ----- src/rfla_rsp_if.sv -----
interface rfla_rsp_if;
	import rfla_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] alloc_value;
	status_t               status;

	modport source (output valid, alloc_value, status, input ready);
	modport sink (input valid, alloc_value, status, output ready);
endinterface

// ----- src/rfla_cfg_if.sv -----
interface rfla_cfg_if;
	logic valid;
	logic ready;
	logic check_enable;

	modport source (output valid, check_enable, input ready);
	modport sink (input valid, check_enable, output ready);
endinterface

// ----- src/rfla_datapath.sv -----
module rfla_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_check_enable,
	input  logic [rfla_pkg::FIELD_BITS-1:0]  range_low,
	input  logic [rfla_pkg::FIELD_BITS-1:0]  range_high,
	input  rfla_pkg::rfla_cmd_t              cmd,
	output rfla_pkg::rfla_stat_t             stat,
	output logic [rfla_pkg::FIELD_BITS-1:0]  alloc_value,
	output rfla_pkg::status_t                status
);
	import rfla_pkg::*;

	val_t    start_q [MAX_RANGES];
	val_t    end_q [MAX_RANGES];
	val_t    start_nxt [MAX_RANGES];
	val_t    end_nxt [MAX_RANGES];
	val_t    start_prv [MAX_RANGES];
	val_t    end_prv [MAX_RANGES];
	val_t    lo_q, hi_q, hi_inc_q, lo_dec_q;
	logic    hi_max_q, lo_zero_q;
	cnt_t    idx_q, count_q;
	logic    check_q;
	val_t    res_val_q;
	status_t res_st_q;
	val_t    s_rd, e_rd;
	cnt_t    idx_next;

	assign s_rd     = start_q[idx_q[IDX_W-1:0]];
	assign e_rd     = end_q[idx_q[IDX_W-1:0]];
	assign idx_next = idx_q + cnt_t'(1);

	for (genvar j = 0; j < MAX_RANGES; j++) begin : g_nbr
		if (j == MAX_RANGES - 1) begin : g_last
			assign start_nxt[j] = start_q[j];
			assign end_nxt[j]   = end_q[j];
		end else begin : g_mid
			assign start_nxt[j] = start_q[j+1];
			assign end_nxt[j]   = end_q[j+1];
		end
		if (j == 0) begin : g_first
			assign start_prv[j] = start_q[j];
			assign end_prv[j]   = end_q[j];
		end else begin : g_rest
			assign start_prv[j] = start_q[j-1];
			assign end_prv[j]   = end_q[j-1];
		end
	end

	always_comb begin
		stat.cnt_zero  = (count_q == '0);
		stat.at_end    = (idx_q == count_q);
		stat.full      = (count_q >= cnt_t'(MAX_RANGES));
		stat.invalid   = check_q && (lo_q > hi_q);
		stat.overlap   = check_q && (((lo_q >= s_rd) && (lo_q <= e_rd)) ||
		                             ((hi_q >= s_rd) && (hi_q <= e_rd)));
		stat.prepend   = !hi_max_q && (s_rd == hi_inc_q);
		stat.append    = !lo_zero_q && (e_rd == lo_dec_q);
		stat.stop      = (s_rd > hi_q);
		stat.has_next  = (idx_next < count_q) && !hi_max_q;
		stat.merge_hit = !hi_max_q && (s_rd == hi_inc_q);
		stat.single    = (s_rd == e_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			check_q <= 1'b1;
		end else begin
			if (cfg_valid) begin
				check_q <= cfg_check_enable;
			end
			if (cmd.ld) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_next;
			end
			if (cmd.drop || cmd.merge) begin
				count_q <= count_q - cnt_t'(1);
			end else if (cmd.open) begin
				count_q <= count_q + cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			lo_q      <= val_t'(range_low);
			hi_q      <= val_t'(range_high);
			hi_inc_q  <= val_t'(range_high) + val_t'(1);
			lo_dec_q  <= val_t'(range_low) - val_t'(1);
			hi_max_q  <= (val_t'(range_high) == VAL_ONES);
			lo_zero_q <= (val_t'(range_low) == '0);
		end
		if (cmd.res_ld) begin
			res_val_q <= cmd.res_ones ? VAL_ONES : s_rd;
			res_st_q  <= cmd.res_status;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_RANGES; j++) begin
			if ((cmd.drop || cmd.merge) && (cnt_t'(j) >= idx_q)) begin
				start_q[j] <= start_nxt[j];
				end_q[j]   <= end_nxt[j];
			end
			if (cmd.merge && (cnt_t'(j) + cnt_t'(1) == idx_q)) begin
				end_q[j] <= e_rd;
			end
			if (cmd.open) begin
				if (cnt_t'(j) > idx_q) begin
					start_q[j] <= start_prv[j];
					end_q[j]   <= end_prv[j];
				end else if (cnt_t'(j) == idx_q) begin
					start_q[j] <= lo_q;
					end_q[j]   <= hi_q;
				end
			end
			if (cmd.wr_start && (cnt_t'(j) == idx_q)) begin
				start_q[j] <= cmd.start_inc ? s_rd + val_t'(1) : lo_q;
			end
			if (cmd.wr_end && (cnt_t'(j) == idx_q)) begin
				end_q[j] <= hi_q;
			end
		end
	end

	assign alloc_value = FIELD_BITS'(res_val_q);
	assign status      = res_st_q;
endmodule

// ----- src/rfla_ctrl.sv -----
module rfla_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_action,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rfla_pkg::rfla_stat_t stat,
	output rfla_pkg::rfla_cmd_t  cmd
);
	import rfla_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_MERGE = 3'd4;
	localparam logic [2:0] S_PLACE = 3'd5;

	logic [2:0] state_q, state_d;
	logic       valid_q;
	logic       go;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = valid_q;
	assign go        = !valid_q || rsp_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.ld  = 1'b1;
					state_d = req_action ? S_CHK : S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (go) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
					if (stat.cnt_zero) begin
						cmd.res_ones   = 1'b1;
						cmd.res_status = ST_EMPTY;
					end else begin
						cmd.res_status = ST_OK;
						if (stat.single) begin
							cmd.drop = 1'b1;
						end else begin
							cmd.wr_start  = 1'b1;
							cmd.start_inc = 1'b1;
						end
					end
				end
			end
			S_CHK: begin
				if (go) begin
					if (stat.invalid) begin
						cmd.res_ld     = 1'b1;
						cmd.res_ones   = 1'b1;
						cmd.res_status = ST_INVALID;
						state_d        = S_IDLE;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (go) begin
					cmd.res_ones   = 1'b1;
					cmd.res_status = ST_OK;
					if (stat.at_end) begin
						state_d = S_PLACE;
					end else if (stat.overlap) begin
						cmd.res_ld     = 1'b1;
						cmd.res_status = ST_OVERLAP;
						state_d        = S_IDLE;
					end else if (stat.prepend) begin
						cmd.wr_start = 1'b1;
						cmd.res_ld   = 1'b1;
						state_d      = S_IDLE;
					end else if (stat.append) begin
						cmd.wr_end = 1'b1;
						if (stat.has_next) begin
							cmd.idx_inc = 1'b1;
							state_d     = S_MERGE;
						end else begin
							cmd.res_ld = 1'b1;
							state_d    = S_IDLE;
						end
					end else if (stat.stop) begin
						state_d = S_PLACE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_MERGE: begin
				if (go) begin
					cmd.merge      = stat.merge_hit;
					cmd.res_ld     = 1'b1;
					cmd.res_ones   = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_IDLE;
				end
			end
			S_PLACE: begin
				if (go) begin
					cmd.res_ld     = 1'b1;
					cmd.res_ones   = 1'b1;
					cmd.open       = !stat.full;
					cmd.res_status = stat.full ? ST_FULL : ST_OK;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_ld) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end
		end
	end
endmodule

// ----- src/range_free_list_allocator_top.sv -----
// channel | dir | beat payload
// req     | in  | action, range_low, range_high
// rsp     | out | alloc_value, status
// cfg     | in  | check_enable (always ready)
//
// An allocate reads the head of the range table; an insert walks the range table,
// one entry a cycle while no result waits unaccepted in the output register.
// Table shifts to open or close a slot update all affected entries together.
// arst_n empties the table and sets check_enable; table contents are not reset.
// A result waiting in the output register stalls the walk of the next beat.
module range_free_list_allocator_top (
	input logic      clk,
	input logic      arst_n,
	rfla_req_if.sink   req,
	rfla_rsp_if.source rsp,
	rfla_cfg_if.sink   cfg
);
	import rfla_pkg::*;

	rfla_cmd_t  cmd;
	rfla_stat_t stat;

	assign cfg.ready = 1'b1;

	rfla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rfla_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg.valid),
		.cfg_check_enable (cfg.check_enable),
		.range_low        (req.range_low),
		.range_high       (req.range_high),
		.cmd              (cmd),
		.stat             (stat),
		.alloc_value      (rsp.alloc_value),
		.status           (rsp.status)
	);
endmodule

// ----- tb/testbench.sv -----
module testbench;
	import rfla_pkg::*;

	localparam logic ACT_ALLOC  = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	localparam int SHADOW_TBL    = 0;
	localparam int PRED_TBL      = 1;
	localparam int QUIET_LIMIT   = 3000;
	localparam int ERR_PRINT_MAX = 100;

	typedef enum int {SINK_STEADY, SINK_RANDOM, SINK_PERIODIC} sink_mode_e;

	typedef struct packed {
		logic action;
		val_t lo;
		val_t hi;
	} req_item_t;

	typedef struct packed {
		val_t    value;
		status_t status;
	} result_t;

	logic clk;
	logic arst_n;

	rfla_req_if req();
	rfla_rsp_if rsp();
	rfla_cfg_if cfg();

	range_free_list_allocator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	val_t        tbl_lo [2][MAX_RANGES];
	val_t        tbl_hi [2][MAX_RANGES];
	int unsigned tbl_cnt [2];
	bit          chk_on [2];

	req_item_t req_backlog [$];
	result_t   due_results [$];
	val_t      held_vals [$];

	int         issued;
	int         mismatches;
	int         gap_left;
	int         burst_left;
	int         quiet_cycles;
	int         sink_cycle;
	sink_mode_e sink_mode;
	val_t       low_ptr;
	val_t       top_ptr;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void remove_entry(input int m, input int unsigned idx);
		int unsigned k;
		for (k = idx; k + 1 < tbl_cnt[m]; k++) begin
			tbl_lo[m][k] = tbl_lo[m][k + 1];
			tbl_hi[m][k] = tbl_hi[m][k + 1];
		end
		tbl_cnt[m]--;
	endfunction

	function automatic status_t insert_span(input int m, input val_t lo, input val_t hi);
		int unsigned i;
		int unsigned k;
		val_t        s;
		val_t        e;
		bit          done;
		bit          brk;
		status_t     st;
		st   = ST_OK;
		done = 1'b0;
		brk  = 1'b0;
		i    = 0;
		if (chk_on[m] && lo > hi) begin
			st   = ST_INVALID;
			done = 1'b1;
		end
		while (!done && !brk && i < tbl_cnt[m]) begin
			s = tbl_lo[m][i];
			e = tbl_hi[m][i];
			if (chk_on[m] && ((lo >= s && lo <= e) || (hi >= s && hi <= e))) begin
				st   = ST_OVERLAP;
				done = 1'b1;
			end else if (hi != VAL_ONES && s == val_t'(hi + 1)) begin
				tbl_lo[m][i] = lo;
				done = 1'b1;
			end else if (lo != '0 && e == val_t'(lo - 1)) begin
				tbl_hi[m][i] = hi;
				if (i + 1 < tbl_cnt[m] && hi != VAL_ONES &&
						val_t'(hi + 1) == tbl_lo[m][i + 1]) begin
					tbl_hi[m][i] = tbl_hi[m][i + 1];
					remove_entry(m, i + 1);
				end
				done = 1'b1;
			end else if (s > hi) begin
				brk = 1'b1;
			end else begin
				i++;
			end
		end
		if (!done) begin
			if (tbl_cnt[m] >= MAX_RANGES) begin
				st = ST_FULL;
			end else begin
				for (k = tbl_cnt[m]; k > i; k--) begin
					tbl_lo[m][k] = tbl_lo[m][k - 1];
					tbl_hi[m][k] = tbl_hi[m][k - 1];
				end
				tbl_lo[m][i] = lo;
				tbl_hi[m][i] = hi;
				tbl_cnt[m]++;
			end
		end
		return st;
	endfunction

	function automatic void apply_request(input int m, input logic act, input val_t lo,
			input val_t hi, output val_t value, output status_t st);
		value = VAL_ONES;
		if (act == ACT_ALLOC) begin
			if (tbl_cnt[m] == 0) begin
				st = ST_EMPTY;
			end else begin
				value = tbl_lo[m][0];
				if (tbl_lo[m][0] == tbl_hi[m][0]) begin
					remove_entry(m, 0);
				end else begin
					tbl_lo[m][0] = tbl_lo[m][0] + 1'b1;
				end
				st = ST_OK;
			end
		end else begin
			st = insert_span(m, lo, hi);
		end
	endfunction

	task automatic queue_item(input logic act, input val_t lo, input val_t hi,
			output val_t v, output status_t st);
		apply_request(SHADOW_TBL, act, lo, hi, v, st);
		req_backlog.push_back('{act, lo, hi});
		issued++;
		if (act == ACT_ALLOC && st == ST_OK) begin
			held_vals.push_back(v);
		end
	endtask

	task automatic free_held();
		int      idx;
		val_t    v;
		val_t    r;
		status_t st;
		if (held_vals.size() == 0) begin
			queue_item(ACT_ALLOC, '0, '0, r, st);
		end else begin
			idx = $urandom_range(0, held_vals.size() - 1);
			v   = held_vals[idx];
			held_vals.delete(idx);
			queue_item(ACT_INSERT, v, v, r, st);
			if (st != ST_OK) begin
				held_vals.push_back(v);
			end
		end
	endtask

	task automatic drain_table();
		int      k;
		val_t    v;
		status_t st;
		for (k = 0; k < 48 && tbl_cnt[SHADOW_TBL] > 0; k++) begin
			queue_item(ACT_ALLOC, '0, '0, v, st);
		end
		repeat ($urandom_range(1, 2)) queue_item(ACT_ALLOC, '0, '0, v, st);
	endtask

	task automatic run_mix(input int count);
		int      stop_at;
		int      pick;
		int      idx;
		val_t    lo;
		val_t    hi;
		val_t    v;
		status_t st;
		stop_at = issued + count;
		while (issued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 28 && held_vals.size() <= 48) begin
				queue_item(ACT_ALLOC, '0, '0, v, st);
			end else if (pick < 58) begin
				free_held();
			end else if (pick < 73) begin
				if ($urandom_range(0, 1)) begin
					lo      = low_ptr + $urandom_range(0, 2);
					hi      = lo + $urandom_range(0, 15);
					low_ptr = hi + 1'b1;
				end else begin
					hi      = top_ptr - $urandom_range(0, 2);
					lo      = hi - $urandom_range(0, 15);
					top_ptr = lo - 1'b1;
				end
				queue_item(ACT_INSERT, lo, hi, v, st);
			end else if (pick < 82) begin
				drain_table();
			end else if (pick < 86) begin
				repeat ($urandom_range(10, 20)) begin
					queue_item(ACT_INSERT, low_ptr, low_ptr, v, st);
					low_ptr = low_ptr + 2;
				end
			end else if (pick < 93) begin
				if (tbl_cnt[SHADOW_TBL] == 0) begin
					free_held();
				end else begin
					idx = $urandom_range(0, tbl_cnt[SHADOW_TBL] - 1);
					lo  = tbl_lo[SHADOW_TBL][idx] + $urandom_range(0, 3);
					hi  = lo + $urandom_range(0, 4);
					queue_item(ACT_INSERT, lo, hi, v, st);
				end
			end else begin
				lo = $urandom;
				if (chk_on[SHADOW_TBL] && $urandom_range(0, 1)) begin
					hi = $urandom;
					if (lo < hi) begin
						v  = lo;
						lo = hi;
						hi = v;
					end
				end else begin
					hi = lo + $urandom_range(0, 7);
				end
				queue_item(ACT_INSERT, lo, hi, v, st);
			end
		end
	endtask

	task automatic set_checking(input bit on);
		@(posedge clk);
		cfg.valid        <= 1'b1;
		cfg.check_enable <= on;
		do @(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		chk_on[SHADOW_TBL] = on;
		chk_on[PRED_TBL]   = on;
		@(negedge clk);
	endtask

	task automatic settle();
		do @(negedge clk);
		while (req_backlog.size() != 0 || req.valid || due_results.size() != 0);
		repeat (MAX_RANGES + 6) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive_req
		val_t      want_value;
		status_t   want_status;
		req_item_t nxt;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				apply_request(PRED_TBL, req.action, req.range_low, req.range_high,
					want_value, want_status);
				due_results.push_back('{want_value, want_status});
			end
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					nxt = req_backlog.pop_front();
					req.valid      <= 1'b1;
					req.action     <= nxt.action;
					req.range_low  <= nxt.lo;
					req.range_high <= nxt.hi;
					if (burst_left > 0) begin
						burst_left--;
					end
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 16);
						if ($urandom_range(0, 9) < 4) begin
							gap_left = 0;
						end else if ($urandom_range(0, 9) == 0) begin
							gap_left = $urandom_range(10, 25);
						end else begin
							gap_left = $urandom_range(1, 4);
						end
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_rsp
		result_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= ERR_PRINT_MAX) begin
						$error("unexpected beat: alloc_value %h, status %0d",
							rsp.alloc_value, rsp.status);
					end
				end else begin
					want = due_results.pop_front();
					if (rsp.alloc_value !== want.value) begin
						mismatches++;
						if (mismatches <= ERR_PRINT_MAX) begin
							$error("alloc_value: expected %h, got %h",
								want.value, rsp.alloc_value);
						end
					end
					if (rsp.status !== want.status) begin
						mismatches++;
						if (mismatches <= ERR_PRINT_MAX) begin
							$error("status: expected %0d, got %0d", want.status, rsp.status);
						end
					end
				end
			end
			sink_cycle++;
			if (sink_cycle % 96 == 0) begin
				sink_mode = sink_mode_e'($urandom_range(0, 2));
			end
			case (sink_mode)
				SINK_STEADY: begin
					rsp.ready <= 1'b1;
				end
				SINK_RANDOM: begin
					rsp.ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					rsp.ready <= ((sink_cycle % 7) < 4);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
					(cfg.valid && cfg.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		val_t    v;
		status_t st;
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.action       = ACT_ALLOC;
		req.range_low    = '0;
		req.range_high   = '0;
		rsp.ready        = 1'b0;
		cfg.valid        = 1'b0;
		cfg.check_enable = 1'b1;
		issued       = 0;
		mismatches   = 0;
		gap_left     = 0;
		burst_left   = 0;
		quiet_cycles = 0;
		sink_cycle   = 0;
		sink_mode    = SINK_STEADY;
		low_ptr      = 64;
		top_ptr      = 32'hFFFF_FEFF;
		for (int m = 0; m < 2; m++) begin
			tbl_cnt[m] = 0;
			chk_on[m]  = 1'b1;
			for (int k = 0; k < MAX_RANGES; k++) begin
				tbl_lo[m][k] = '0;
				tbl_hi[m][k] = '0;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_checking(1'b1);
		queue_item(ACT_ALLOC, '0, '0, v, st);
		queue_item(ACT_INSERT, 10, 12, v, st);
		queue_item(ACT_INSERT, 13, 20, v, st);
		queue_item(ACT_INSERT, 5, 9, v, st);
		queue_item(ACT_INSERT, 30, 40, v, st);
		queue_item(ACT_INSERT, 21, 29, v, st);
		queue_item(ACT_INSERT, 15, 16, v, st);
		queue_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, v, st);
		queue_item(ACT_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, v, st);
		queue_item(ACT_INSERT, 0, 0, v, st);
		queue_item(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, v, st);
		queue_item(ACT_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFE, v, st);
		queue_item(ACT_INSERT, 41, 41, v, st);
		queue_item(ACT_ALLOC, '0, '0, v, st);
		queue_item(ACT_ALLOC, '0, '0, v, st);
		settle();

		set_checking(1'b0);
		queue_item(ACT_INSERT, 32'hFFFF_FFFE, 32'h0000_0001, v, st);
		queue_item(ACT_INSERT, 8, 9, v, st);
		repeat (6) queue_item(ACT_ALLOC, '0, '0, v, st);
		settle();

		set_checking(1'b1);
		run_mix(600);
		settle();

		set_checking(1'b0);
		run_mix(250);
		drain_table();
		settle();

		set_checking(1'b1);
		run_mix(500);
		settle();

		set_checking(1'b0);
		run_mix(150);
		drain_table();
		settle();

		set_checking(1'b1);
		run_mix(250);
		settle();

		if (mismatches == 0 && due_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/rfla_pkg.sv
src/rfla_req_if.sv
src/rfla_rsp_if.sv
src/rfla_cfg_if.sv
src/rfla_datapath.sv
src/rfla_ctrl.sv
src/range_free_list_allocator_top.sv
tb/testbench.sv
